// File: rtl/plin_pkg.sv
package plin_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 64;
	localparam int VAL_W = 32;
	localparam int IDX_W = 6;
	localparam int CNT_W = 7;
	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Word index of the register on the configuration port (paddr[2]).
	localparam logic REG_POINTS_IN_USE = 1'b0;

	typedef enum logic {
		ACT_QUERY = 1'b0,
		ACT_WRITE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LAST_RD,
		ST_LAST_CHK,
		ST_SCAN,
		ST_DIFF,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic                   start;
		logic [2*VAL_W-1:0]     dividend;
		logic [VAL_W-1:0]       divisor;
	} div_req_t;

	typedef struct packed {
		logic                   done;
		logic [VAL_W-1:0]       quotient;
	} div_rsp_t;

endpackage

// File: rtl/piecewise_linear_interpolator.sv
// Piecewise linear interpolator over a table of signed Q16.16 breakpoints held
// in two single-port-read memories (x and y). A request with tuser set writes
// one breakpoint in the cycle it is accepted and gives no result; a request
// with tuser clear is a query and gives exactly one result, whose tuser carries
// the status (ok, table empty, query out of range) and whose value is zero on
// error. The number of valid breakpoints is set through the APB register at
// byte address 0 and should only be changed while no query is in flight. A
// query first reads the last valid abscissa for the range check, then scans
// the x memory from entry 0 one entry a cycle until it meets the first
// abscissa not below the query; unless the hit is on entry 0, it then forms
// the 64-bit product and runs a 32-step restoring division. The memories
// are not cleared after reset; entries must be written before a query can
// reach them. The input side accepts the next request as soon as the
// previous result has been loaded into the output register.
module piecewise_linear_interpolator #(
	parameter int TABLE_DEPTH = plin_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	// Input stream.
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata, from bit 0 up: point_index[5:0], point_x[37:6], point_y[69:38],
	// query_x[101:70], two zero bits of padding.
	input  logic [103:0] s_axis_tdata,
	// tuser: action[0] (0 query, 1 write breakpoint).
	input  logic [0:0]   s_axis_tuser,
	// Result stream.
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: value[31:0].
	output logic [31:0]  m_axis_tdata,
	// tuser: status[1:0].
	output logic [1:0]   m_axis_tuser,
	// Configuration port.
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import plin_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// Unpacked request fields.
	logic [IDX_W-1:0] in_index;
	logic [VAL_W-1:0] in_x;
	logic [VAL_W-1:0] in_y;
	logic [VAL_W-1:0] in_query;
	logic             in_accept;

	assign in_index  = s_axis_tdata[5:0];
	assign in_x      = s_axis_tdata[37:6];
	assign in_y      = s_axis_tdata[69:38];
	assign in_query  = s_axis_tdata[101:70];
	assign in_accept = s_axis_tvalid && s_axis_tready;

	// Configuration register.
	logic [CNT_W-1:0] points_q;
	logic             cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_POINTS_IN_USE) ? 32'(points_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= '0;
		end else if (cfg_write && (paddr[2] == REG_POINTS_IN_USE)) begin
			points_q <= pwdata[CNT_W-1:0];
		end
	end

	// Index of the last valid entry; a count above the depth is clipped to it.
	logic [AW-1:0] last_idx;
	logic          table_empty;

	always_comb begin
		table_empty = (points_q == '0);
		if (32'(points_q) >= 32'(TABLE_DEPTH)) begin
			last_idx = AW'(TABLE_DEPTH - 1);
		end else begin
			last_idx = AW'(points_q - 1'b1);
		end
	end

	// Breakpoint memories.
	logic             wr_en;
	logic [AW-1:0]    rd_addr;
	logic [VAL_W-1:0] rd_x;
	logic [VAL_W-1:0] rd_y;

	// A write to a slot beyond the table is dropped.
	assign wr_en = in_accept && (action_t'(s_axis_tuser[0]) == ACT_WRITE)
		&& (32'(in_index) < 32'(TABLE_DEPTH));

	plin_table #(
		.DEPTH(TABLE_DEPTH),
		.AW   (AW)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(AW'(in_index)),
		.wr_x   (in_x),
		.wr_y   (in_y),
		.rd_addr(rd_addr),
		.rd_x   (rd_x),
		.rd_y   (rd_y)
	);

	// Divider.
	div_req_t div_req;
	div_rsp_t div_rsp;

	plin_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Datapath registers.
	state_t             state_q, state_d;
	logic [AW-1:0]      cmp_q;
	logic [VAL_W-1:0]   query_q;
	logic [VAL_W-1:0]   prev_x_q, prev_y_q;
	logic [VAL_W-1:0]   x_lo_q, x_hi_q, y_lo_q, y_hi_q;
	logic [VAL_W-1:0]   dx_q, den_q, dy_mag_q;
	logic               neg_q;
	logic [2*VAL_W-1:0] prod_q;
	logic [VAL_W-1:0]   res_value_q;
	status_t            res_status_q;
	logic               out_valid_q;
	logic [VAL_W-1:0]   out_value_q;
	status_t            out_status_q;

	// The memory word just read is compared with the query as a signed value.
	logic hit;
	logic above_last;
	logic out_free;

	assign hit        = $signed(rd_x) >= $signed(query_q);
	assign above_last = $signed(query_q) > $signed(rd_x);
	assign out_free   = !out_valid_q || m_axis_tready;

	// Next state, read address and handshake.
	always_comb begin
		state_d       = state_q;
		rd_addr       = '0;
		s_axis_tready = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = prod_q;
		div_req.divisor  = den_q;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (in_accept && (action_t'(s_axis_tuser[0]) == ACT_QUERY)) begin
					state_d = table_empty ? ST_RESULT : ST_LAST_RD;
				end
			end
			ST_LAST_RD: begin
				rd_addr = last_idx;
				state_d = ST_LAST_CHK;
			end
			ST_LAST_CHK: begin
				// Entry 0 is fetched here so the scan starts without a bubble.
				rd_addr = '0;
				state_d = above_last ? ST_RESULT : ST_SCAN;
			end
			ST_SCAN: begin
				rd_addr = cmp_q + 1'b1;
				if (hit) begin
					state_d = (cmp_q == '0) ? ST_RESULT : ST_DIFF;
				end
			end
			ST_DIFF: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				div_req.start = 1'b1;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Query datapath. Every difference below is known to lie in the range of
	// an unsigned word, so modular 32-bit subtraction gives it exactly.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				query_q      <= in_query;
				res_value_q  <= '0;
				res_status_q <= STAT_EMPTY;
			end
			ST_LAST_CHK: begin
				cmp_q        <= '0;
				res_value_q  <= '0;
				res_status_q <= STAT_RANGE;
			end
			ST_SCAN: begin
				if (hit) begin
					// A hit on the first entry is exact or below the table.
					if (rd_x == query_q) begin
						res_value_q  <= rd_y;
						res_status_q <= STAT_OK;
					end else begin
						res_value_q  <= '0;
						res_status_q <= STAT_RANGE;
					end
					x_lo_q <= prev_x_q;
					y_lo_q <= prev_y_q;
					x_hi_q <= rd_x;
					y_hi_q <= rd_y;
				end else begin
					prev_x_q <= rd_x;
					prev_y_q <= rd_y;
					cmp_q    <= cmp_q + 1'b1;
				end
			end
			ST_DIFF: begin
				dx_q     <= query_q - x_lo_q;
				den_q    <= x_hi_q - x_lo_q;
				neg_q    <= $signed(y_hi_q) < $signed(y_lo_q);
				dy_mag_q <= ($signed(y_hi_q) < $signed(y_lo_q)) ?
					(y_lo_q - y_hi_q) : (y_hi_q - y_lo_q);
			end
			ST_MUL: begin
				prod_q <= (2*VAL_W)'(dx_q) * (2*VAL_W)'(dy_mag_q);
			end
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					res_value_q  <= neg_q ? (y_lo_q - div_rsp.quotient)
						: (y_lo_q + div_rsp.quotient);
					res_status_q <= STAT_OK;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: the finished result waits here for the sink.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_RESULT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RESULT) && out_free) begin
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_value_q;
	assign m_axis_tuser  = out_status_q;

endmodule

// File: rtl/plin_table.sv
module plin_table #(
	parameter int DEPTH = plin_pkg::DEFAULT_TABLE_DEPTH,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [plin_pkg::VAL_W-1:0] wr_x,
	input  logic [plin_pkg::VAL_W-1:0] wr_y,
	input  logic [AW-1:0]              rd_addr,
	output logic [plin_pkg::VAL_W-1:0] rd_x,
	output logic [plin_pkg::VAL_W-1:0] rd_y
);
	import plin_pkg::*;

	// Breakpoint abscissae and ordinates, one synchronous read port each.
	logic [VAL_W-1:0] x_mem [DEPTH];
	logic [VAL_W-1:0] y_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			x_mem[wr_addr] <= wr_x;
			y_mem[wr_addr] <= wr_y;
		end
		rd_x <= x_mem[rd_addr];
		rd_y <= y_mem[rd_addr];
	end

endmodule

// File: rtl/plin_divider.sv
module plin_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  plin_pkg::div_req_t  req,
	output plin_pkg::div_rsp_t  rsp
);
	import plin_pkg::*;

	// Restoring division, one quotient bit a cycle. The caller guarantees that
	// the upper half of the dividend is below the divisor, so the quotient fits
	// in one word and the partial remainder never exceeds one word.
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [VAL_W-1:0]     rem_q;
	logic [VAL_W-1:0]     low_q;
	logic [VAL_W-1:0]     divisor_q;
	logic [VAL_W:0]       trial;
	logic [VAL_W:0]       diff;
	logic                 fits;

	always_comb begin
		trial = {rem_q, low_q[VAL_W-1]};
		diff  = trial - {1'b0, divisor_q};
		fits  = trial >= {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= req.dividend[2*VAL_W-1:VAL_W];
			low_q     <= req.dividend[VAL_W-1:0];
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
			low_q <= {low_q[VAL_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = low_q;

endmodule

// File: rtl/plin_checker.sv
module plin_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [0:0]   s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [31:0]  m_axis_tdata,
	input  logic [1:0]   m_axis_tuser
);
	import plin_pkg::*;

	// A stalled result holds its value and status.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// An error result always carries a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != STAT_OK) |-> m_axis_tdata == 32'd0)
		else $error("error result with non-zero value");

	// A breakpoint write completes at once and leaves the block ready.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == ACT_WRITE)
			|=> s_axis_tready)
		else $error("ready dropped after a write");

	// A query occupies the block for at least the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == ACT_QUERY)
			|=> !s_axis_tready)
		else $error("ready stayed high after a query");

endmodule

bind piecewise_linear_interpolator plin_checker u_plin_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);
